/* rtl/core/cpe_pkg.sv */
// Shared types and constants for the column post encoder.
// Holds the request, response and work descriptor structs and the slot codes.
// No dependencies.
`timescale 1ns / 1ps

package cpe_pkg;

   localparam int POSITION_BITS_DEFAULT = 20;
   localparam int COLUMN_BITS_DEFAULT   = 10;
   localparam int POS_FIELD_W           = 20;
   localparam int COL_FIELD_W           = 10;
   localparam int BYTE_W                = 8;
   localparam int HEIGHT_W              = 8;
   localparam int QUEUE_DEPTH           = 4;

   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 8'd128;
   localparam logic [BYTE_W-1:0]   TERMINATOR   = 8'hFF;
   localparam logic [BYTE_W-1:0]   SATURATED    = 8'hFF;

   // Result slots of one pixel, in the order their beats leave the block.
   localparam int NUM_SLOTS  = 6;
   localparam int SLOT_COL   = 0;  // column start record
   localparam int SLOT_B0    = 1;  // gap byte of a new post, or a palette byte
   localparam int SLOT_B1    = 2;  // provisional length byte
   localparam int SLOT_B2    = 3;  // first palette byte of a new post
   localparam int SLOT_PATCH = 4;  // length byte rewrite
   localparam int SLOT_TERM  = 5;  // column terminator

   localparam logic KIND_BYTE   = 1'b0;
   localparam logic KIND_COLUMN = 1'b1;

   typedef struct packed {
      logic              opaque;
      logic [BYTE_W-1:0] pal_byte;
      logic              first_of_patch;
   } cpe_req_type;

   typedef struct packed {
      logic                   kind;
      logic [POS_FIELD_W-1:0] position;
      logic [COL_FIELD_W-1:0] column;
      logic [BYTE_W-1:0]      value;
      logic                   overflow;
      logic                   last;
   } cpe_rsp_type;

   // Fixed-width part of the work descriptor passed from front to back.
   typedef struct packed {
      logic [NUM_SLOTS-1:0] slots;
      logic                 start_post;
      logic                 overflow;
      logic [BYTE_W-1:0]    gap;
      logic [BYTE_W-1:0]    palette;
      logic [BYTE_W-1:0]    run;
   } cpe_desc_type;

endpackage

/* rtl/core/column_post_encoder.sv */
// Top level of the column post encoder: front end, descriptor queue, back end.
// Depends on cpe_pkg, cpe_front, cpe_queue and cpe_back.
//
//   Channel   Direction   Handshake        Beat contents
//   req_      in          valid / stall    one pixel: opaque, pal_byte, first_of_patch
//   rsp_      out         valid / stall    one write: kind, position, column, value,
//                                          overflow, last
//   csr_      in          valid / ready    column_height, 8 bits
//
// The front end takes one pixel per cycle whenever the descriptor queue has room,
// so a pixel is accepted in the cycle it arrives while older work drains.
// With the back end idle, the first beat of a pixel passes from the queue entry
// into the back end's slot and descriptor registers, then into the output register
// before it is offered on rsp_.
// The back end sends one result beat per cycle while rsp_stall is low; a pixel
// causes zero to six beats, so throughput is set by the single output register.
// A stall on rsp_ holds the output beat, then backs up into the four-entry queue,
// and only a full queue raises req_stall.
// Reset is synchronous and active high; it clears the encoder state, restores
// column_height to 128 and empties the queue. No clearing pass is needed.
`timescale 1ns / 1ps

module column_post_encoder #(
   parameter int POSITION_BITS = cpe_pkg::POSITION_BITS_DEFAULT,
   parameter int COLUMN_BITS   = cpe_pkg::COLUMN_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  cpe_pkg::cpe_req_type         req_data,
   output logic                         req_stall,
   output logic                         rsp_valid,
   output cpe_pkg::cpe_rsp_type         rsp_data,
   input  logic                         rsp_stall,
   input  logic                         csr_valid,
   input  logic [cpe_pkg::HEIGHT_W-1:0] csr_data,
   output logic                         csr_ready
);
   import cpe_pkg::*;

   // A queue entry carries the fixed descriptor plus the positions and column,
   // whose widths follow the parameters.
   localparam int DESC_W  = $bits(cpe_desc_type);
   localparam int ENTRY_W = DESC_W + 2 * POSITION_BITS + COLUMN_BITS;

   logic                     push;
   logic                     pop;
   logic                     queue_full;
   logic                     queue_empty;
   cpe_desc_type             front_desc;
   logic [POSITION_BITS-1:0] front_pos;
   logic [POSITION_BITS-1:0] front_patch_pos;
   logic [COLUMN_BITS-1:0]   front_column;
   logic [ENTRY_W-1:0]       push_entry;
   logic [ENTRY_W-1:0]       pop_entry;
   cpe_desc_type             back_desc;
   logic [POSITION_BITS-1:0] back_pos;
   logic [POSITION_BITS-1:0] back_patch_pos;
   logic [COLUMN_BITS-1:0]   back_column;

   // The front end owns the column_height register and all per-column state.
   cpe_front #(
      .POSITION_BITS (POSITION_BITS),
      .COLUMN_BITS   (COLUMN_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_data       (req_data),
      .req_stall      (req_stall),
      .csr_valid      (csr_valid),
      .csr_data       (csr_data),
      .csr_ready      (csr_ready),
      .queue_full     (queue_full),
      .push           (push),
      .desc           (front_desc),
      .desc_pos       (front_pos),
      .desc_patch_pos (front_patch_pos),
      .desc_column    (front_column)
   );

   assign push_entry = {front_desc, front_pos, front_patch_pos, front_column};

   cpe_queue #(
      .DATA_W (ENTRY_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_entry),
      .pop       (pop),
      .pop_data  (pop_entry),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   assign {back_desc, back_pos, back_patch_pos, back_column} = pop_entry;

   // The back end replays the descriptor as beats and tracks the write
   // position and overflow flag beat by beat.
   cpe_back #(
      .POSITION_BITS (POSITION_BITS),
      .COLUMN_BITS   (COLUMN_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_empty    (queue_empty),
      .desc           (back_desc),
      .desc_pos       (back_pos),
      .desc_patch_pos (back_patch_pos),
      .desc_column    (back_column),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .rsp_stall      (rsp_stall)
   );

   // Once a beat reports overflow, every later beat must report it too.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.overflow) |=> (!rsp_valid || rsp_data.overflow))
      else $error("overflow flag dropped after being set");

   // The queue cannot be full and empty at once.
   assert property (@(posedge clock) disable iff (reset)
      !(queue_full && queue_empty))
      else $error("descriptor queue reports full and empty together");

   // Nothing is pushed into a full queue.
   assert property (@(posedge clock) disable iff (reset)
      queue_full |-> !push)
      else $error("descriptor pushed into a full queue");

   // Reset leaves no beat on the output.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat valid right after reset");

endmodule

/* rtl/core/cpe_front.sv */
// Front end of the column post encoder: accepts pixels, keeps the column and post
// state, and emits a work descriptor for each pixel with result beats. Uses cpe_pkg.
`timescale 1ns / 1ps

module cpe_front #(
   parameter int POSITION_BITS = 20,
   parameter int COLUMN_BITS   = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  cpe_pkg::cpe_req_type           req_data,
   output logic                           req_stall,
   input  logic                           csr_valid,
   input  logic [cpe_pkg::HEIGHT_W-1:0]   csr_data,
   output logic                           csr_ready,
   input  logic                           queue_full,
   output logic                           push,
   output cpe_pkg::cpe_desc_type          desc,
   output logic [POSITION_BITS-1:0]       desc_pos,
   output logic [POSITION_BITS-1:0]       desc_patch_pos,
   output logic [COLUMN_BITS-1:0]         desc_column
);
   import cpe_pkg::*;

   logic [HEIGHT_W-1:0]      height_ff;
   logic                     in_post_ff, in_post_in;
   logic [POSITION_BITS-1:0] post_start_ff, post_start_in;
   logic [BYTE_W-1:0]        gap_ff, gap_in;
   logic [BYTE_W-1:0]        run_ff, run_in;
   logic [HEIGHT_W-1:0]      row_ff, row_in;
   logic [COLUMN_BITS-1:0]   column_ff, column_in;
   logic [POSITION_BITS-1:0] wpos_ff, wpos_in;
   logic                     overflow_ff, overflow_in;

   logic                     accept;
   logic [NUM_SLOTS-1:0]     slots;
   logic                     start_post;
   logic [BYTE_W-1:0]        run_out;
   logic [COLUMN_BITS-1:0]   column_e;
   logic [POSITION_BITS-1:0] wpos_e;

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      logic                  restart;
      logic [HEIGHT_W-1:0]   row_e;
      logic                  in_post_e;
      logic [BYTE_W-1:0]     gap_e;
      logic [BYTE_W-1:0]     run_e;
      logic [HEIGHT_W-1:0]   height;
      logic [2:0]            nbytes;
      logic [POSITION_BITS:0] sum;

      restart   = req_data.first_of_patch;
      column_e  = restart ? '0 : column_ff;
      wpos_e    = restart ? '0 : wpos_ff;
      row_e     = restart ? '0 : row_ff;
      in_post_e = restart ? 1'b0 : in_post_ff;
      gap_e     = restart ? '0 : gap_ff;
      run_e     = restart ? '0 : run_ff;
      height    = (height_ff == '0) ? HEIGHT_W'(1) : height_ff;

      slots         = '0;
      start_post    = 1'b0;
      run_out       = '0;
      nbytes        = '0;
      post_start_in = post_start_ff;
      in_post_in    = in_post_e;
      gap_in        = gap_e;
      run_in        = run_e;
      column_in     = column_e;

      slots[SLOT_COL] = (row_e == '0);

      if (!in_post_e) begin
         if (req_data.opaque) begin
            start_post     = 1'b1;
            post_start_in  = wpos_e;
            run_in         = BYTE_W'(1);
            slots[SLOT_B0] = 1'b1;
            slots[SLOT_B1] = 1'b1;
            slots[SLOT_B2] = 1'b1;
            nbytes         = 3'd3;
            gap_in         = '0;
            in_post_in     = 1'b1;
         end else if (gap_e != SATURATED) begin
            gap_in = gap_e + BYTE_W'(1);
         end
      end else begin
         if (req_data.opaque) begin
            if (run_e != SATURATED) begin
               run_in = run_e + BYTE_W'(1);
            end
            slots[SLOT_B0] = 1'b1;
            nbytes         = 3'd1;
         end else begin
            // A transparent pixel closes the post and counts toward the next gap.
            slots[SLOT_PATCH] = 1'b1;
            run_out           = run_e;
            in_post_in        = 1'b0;
            run_in            = '0;
            gap_in            = BYTE_W'(1);
         end
      end

      row_in = row_e + HEIGHT_W'(1);
      if (row_in >= height || row_in == '0) begin
         if (in_post_in) begin
            slots[SLOT_PATCH] = 1'b1;
            run_out           = run_in;
         end
         slots[SLOT_TERM] = 1'b1;
         nbytes           = nbytes + 3'd1;
         in_post_in       = 1'b0;
         run_in           = '0;
         gap_in           = '0;
         row_in           = '0;
         column_in        = column_e + COLUMN_BITS'(1);
      end

      sum         = {1'b0, wpos_e} + (POSITION_BITS + 1)'(nbytes);
      wpos_in     = sum[POSITION_BITS-1:0];
      overflow_in = overflow_ff | sum[POSITION_BITS];
   end

   assign push            = accept && (slots != '0);
   assign desc.slots      = slots;
   assign desc.start_post = start_post;
   assign desc.overflow   = overflow_ff;
   assign desc.gap        = gap_ff & {BYTE_W{!req_data.first_of_patch}};
   assign desc.palette    = req_data.pal_byte;
   assign desc.run        = run_out;
   assign desc_pos        = wpos_e;
   assign desc_patch_pos  = post_start_in + POSITION_BITS'(1);
   assign desc_column     = column_e;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff     <= HEIGHT_RESET;
         in_post_ff    <= 1'b0;
         post_start_ff <= '0;
         gap_ff        <= '0;
         run_ff        <= '0;
         row_ff        <= '0;
         column_ff     <= '0;
         wpos_ff       <= '0;
         overflow_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            height_ff <= csr_data;
         end
         if (accept) begin
            in_post_ff    <= in_post_in;
            post_start_ff <= post_start_in;
            gap_ff        <= gap_in;
            run_ff        <= run_in;
            row_ff        <= row_in;
            column_ff     <= column_in;
            wpos_ff       <= wpos_in;
            overflow_ff   <= overflow_in;
         end
      end
   end

endmodule

/* rtl/core/cpe_queue.sv */
// Small descriptor queue between the front and back of the column post encoder.
// Register array with head and tail pointers. Uses cpe_pkg only for style.
`timescale 1ns / 1ps

module cpe_queue #(
   parameter int DATA_W = 64,
   parameter int DEPTH  = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              full,
   output logic              empty
);
   import cpe_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [IDX_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + IDX_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + IDX_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/core/cpe_back.sv */
// Back end of the column post encoder: expands each work descriptor into
// result beats through a registered output, one per cycle unless stalled. Uses cpe_pkg.
`timescale 1ns / 1ps

module cpe_back #(
   parameter int POSITION_BITS = 20,
   parameter int COLUMN_BITS   = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      queue_empty,
   input  cpe_pkg::cpe_desc_type     desc,
   input  logic [POSITION_BITS-1:0]  desc_pos,
   input  logic [POSITION_BITS-1:0]  desc_patch_pos,
   input  logic [COLUMN_BITS-1:0]    desc_column,
   output logic                      pop,
   output logic                      rsp_valid,
   output cpe_pkg::cpe_rsp_type      rsp_data,
   input  logic                      rsp_stall
);
   import cpe_pkg::*;

   logic [NUM_SLOTS-1:0]     slots_ff, slots_in;
   cpe_desc_type             desc_ff;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] patch_ff;
   logic [COLUMN_BITS-1:0]   column_ff;
   logic                     overflow_ff, overflow_in;
   logic                     rsp_valid_ff;
   cpe_rsp_type              rsp_data_ff;

   logic [NUM_SLOTS-1:0]     sel;
   logic [NUM_SLOTS-1:0]     rest;
   logic                     emit;
   logic                     is_byte;
   cpe_rsp_type              beat;

   assign sel     = slots_ff & (~slots_ff + NUM_SLOTS'(1));
   assign rest    = slots_ff & ~sel;
   assign emit    = (slots_ff != '0) && (!rsp_valid_ff || !rsp_stall);
   assign is_byte = sel[SLOT_B0] | sel[SLOT_B1] | sel[SLOT_B2] | sel[SLOT_TERM];
   assign pop     = !queue_empty && ((slots_ff == '0) || (emit && rest == '0));

   always_comb begin
      beat          = '0;
      beat.kind     = sel[SLOT_COL] ? KIND_COLUMN : KIND_BYTE;
      beat.position = sel[SLOT_PATCH] ? POS_FIELD_W'(patch_ff) : POS_FIELD_W'(pos_ff);
      beat.column   = sel[SLOT_COL] ? COL_FIELD_W'(column_ff) : '0;
      beat.overflow = overflow_ff;
      beat.last     = (rest == '0);
      if (sel[SLOT_B0]) begin
         beat.value = desc_ff.start_post ? desc_ff.gap : desc_ff.palette;
      end else if (sel[SLOT_B1]) begin
         beat.value = BYTE_W'(1);
      end else if (sel[SLOT_B2]) begin
         beat.value = desc_ff.palette;
      end else if (sel[SLOT_PATCH]) begin
         beat.value = desc_ff.run;
      end else if (sel[SLOT_TERM]) begin
         beat.value = TERMINATOR;
      end else begin
         beat.value = '0;
      end

      slots_in    = emit ? rest : slots_ff;
      pos_in      = pos_ff;
      overflow_in = overflow_ff;
      if (emit && is_byte) begin
         pos_in      = pos_ff + POSITION_BITS'(1);
         overflow_in = overflow_ff | (pos_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slots_ff <= pop ? desc.slots : slots_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         desc_ff     <= desc;
         pos_ff      <= desc_pos;
         patch_ff    <= desc_patch_pos;
         column_ff   <= desc_column;
         overflow_ff <= desc.overflow;
      end else begin
         pos_ff      <= pos_in;
         overflow_ff <= overflow_in;
      end
      if (emit) begin
         rsp_data_ff <= beat;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
